### sv/slab_chunk_allocator_core_defines.svh
// assertion macros for the slab chunk allocator checker
`ifndef SLAB_CHUNK_ALLOCATOR_CORE_DEFINES_SVH
`define SLAB_CHUNK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SCA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slab chunk allocator check failed");

// next-cycle implication
`define SCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slab chunk allocator check failed");

`endif

### sv/sca_pkg.sv
// types and constants shared by the slab chunk allocator modules
package sca_pkg;

    localparam int ADDR_W     = 48;
    localparam int CHUNK_W    = 17;
    localparam int COUNT_W    = 9;
    localparam int IDX_W      = 8;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int DIV_STEPS  = 17;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [ADDR_W-1:0]  RST_SLAB_BASE   = 48'd0;
    localparam logic [CHUNK_W-1:0] RST_CHUNK_BYTES = 17'd64;
    localparam logic [CHUNK_W-1:0] RST_SLAB_BYTES  = 17'd65536;
    localparam logic [COUNT_W-1:0] RST_CHUNK_COUNT = 9'd256;

    typedef enum logic [1:0] {
        STS_OK,
        STS_NO_FREE,
        STS_OUTSIDE,
        STS_DOUBLE_FREE
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] free_address;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  chunk_address;
        logic [IDX_W-1:0]   chunk_index;
        logic [COUNT_W-1:0] allocated_now;
        logic               has_room;
        logic               left_full;
        logic               now_empty;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ARD,
        S_AEVAL,
        S_AMUL,
        S_FRANGE,
        S_DIV,
        S_FIDX,
        S_FRD,
        S_FEVAL,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clr;
        logic accept;
        logic a_eval;
        logic f_range;
        logic div_step;
        logic f_idx;
        logic f_eval;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic a_found;
        logic a_more;
        logic range_bad;
        logic div_last;
        logic idx_bad;
    } t_sts;

endpackage

### sv/sca_ctrl.sv
// controller state machine of the slab chunk allocator
module sca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_mode,
    input  logic          i_out_stall,
    input  sca_pkg::t_sts i_sts,
    output sca_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    sca_pkg::t_state r_state;
    sca_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sca_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sca_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = sca_pkg::S_IDLE;
            end
            sca_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_mode == sca_pkg::MODE_FREE) ? sca_pkg::S_FRANGE
                                                                : sca_pkg::S_ARD;
                end
            end
            sca_pkg::S_ARD:   n_state = sca_pkg::S_AEVAL;
            sca_pkg::S_AEVAL: begin
                if (i_sts.a_found) n_state = sca_pkg::S_AMUL;
                else if (i_sts.a_more) n_state = sca_pkg::S_ARD;
                else n_state = sca_pkg::S_FINISH;
            end
            sca_pkg::S_AMUL:  n_state = sca_pkg::S_FINISH;
            sca_pkg::S_FRANGE: begin
                n_state = i_sts.range_bad ? sca_pkg::S_FINISH : sca_pkg::S_DIV;
            end
            sca_pkg::S_DIV: begin
                if (i_sts.div_last) n_state = sca_pkg::S_FIDX;
            end
            sca_pkg::S_FIDX: begin
                n_state = i_sts.idx_bad ? sca_pkg::S_FINISH : sca_pkg::S_FRD;
            end
            sca_pkg::S_FRD:   n_state = sca_pkg::S_FEVAL;
            sca_pkg::S_FEVAL: n_state = sca_pkg::S_FINISH;
            sca_pkg::S_FINISH: begin
                if (slot_free) n_state = sca_pkg::S_IDLE;
            end
            default: n_state = sca_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = (r_state != sca_pkg::S_IDLE);
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            sca_pkg::S_CLEAR:  o_cmd.clr      = 1'b1;
            sca_pkg::S_IDLE:   o_cmd.accept   = i_in_valid;
            sca_pkg::S_AEVAL:  o_cmd.a_eval   = 1'b1;
            sca_pkg::S_FRANGE: o_cmd.f_range  = 1'b1;
            sca_pkg::S_DIV:    o_cmd.div_step = 1'b1;
            sca_pkg::S_FIDX:   o_cmd.f_idx    = 1'b1;
            sca_pkg::S_FEVAL:  o_cmd.f_eval   = 1'b1;
            sca_pkg::S_FINISH: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### sv/sca_datapath.sv
// datapath of the slab chunk allocator: config, used map, scan, divider, result
module sca_datapath #(
    parameter int MAX_CHUNKS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sca_pkg::t_cmd                       i_cmd,
    output sca_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sca_pkg::ADDR_W-1:0]          i_cfg_data,
    input  sca_pkg::t_in_word                   i_in_data,
    output sca_pkg::t_out_word                  o_out_data
);

    localparam int IW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW    = $clog2(MAX_CHUNKS + 1);
    localparam int WORDS = (MAX_CHUNKS + sca_pkg::WORD_BITS - 1) / sca_pkg::WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = WAW + sca_pkg::BIT_W + 1;
    localparam int PRW   = IW + sca_pkg::CHUNK_W;

    logic [sca_pkg::ADDR_W-1:0]  r_slab_base;
    logic [sca_pkg::CHUNK_W-1:0] r_chunk_bytes;
    logic [sca_pkg::CHUNK_W-1:0] r_slab_bytes;
    logic [sca_pkg::COUNT_W-1:0] r_chunk_count;

    logic [CW-1:0]               r_used_count;
    logic [IW-1:0]               r_hint;
    logic [WAW-1:0]              r_clr_idx;

    logic [sca_pkg::WORD_BITS-1:0] r_mem [WORDS];
    logic [sca_pkg::WORD_BITS-1:0] r_rd_data;

    logic                        r_mode;
    logic [sca_pkg::ADDR_W-1:0]  r_addr;
    sca_pkg::t_status            r_status;
    logic [IW-1:0]               r_idx;
    logic [WAW-1:0]              r_widx;
    logic [sca_pkg::BIT_W-1:0]   r_bsel;
    logic                        r_left_full;
    logic                        r_now_empty;
    logic [PRW-1:0]              r_prod;
    logic [sca_pkg::CHUNK_W-1:0] r_quo;
    logic [sca_pkg::CHUNK_W-1:0] r_rem;
    logic [sca_pkg::DIV_CNT_W-1:0] r_div_cnt;
    sca_pkg::t_out_word          r_out;

    logic [CW-1:0]               n_c;
    logic [sca_pkg::CHUNK_W-1:0] eff_chunk;
    logic [PW-1:0]               hint_p;
    logic [PW-1:0]               n_p;
    logic [WAW:0]                hint_w;
    logic [WAW:0]                n_w;
    logic [WAW:0]                widx_x;
    logic [sca_pkg::BIT_W-1:0]   hint_b;
    logic [sca_pkg::BIT_W-1:0]   n_b;
    logic [sca_pkg::WORD_BITS-1:0] elig;
    logic [sca_pkg::BIT_W-1:0]   a_sel;
    logic [IW-1:0]               a_idx;
    logic                        a_found;
    logic                        a_more;
    logic [sca_pkg::ADDR_W:0]    diff;
    logic                        range_bad;
    logic [sca_pkg::CHUNK_W:0]   div_t;
    logic                        div_ge;
    logic                        idx_bad;
    logic                        bit_used;
    logic                        mem_we;
    logic [WAW-1:0]              mem_waddr;
    logic [sca_pkg::WORD_BITS-1:0] mem_wdata;

    assign n_c = (32'(r_chunk_count) > 32'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS)
                                                         : CW'(r_chunk_count);
    assign eff_chunk = (r_chunk_bytes == '0) ? sca_pkg::CHUNK_W'(1) : r_chunk_bytes;

    // scan window of the current map word
    always_comb begin
        hint_p = PW'(r_hint);
        n_p    = PW'(n_c);
        hint_w = (WAW + 1)'(hint_p >> sca_pkg::BIT_W);
        n_w    = (WAW + 1)'(n_p >> sca_pkg::BIT_W);
        hint_b = hint_p[sca_pkg::BIT_W-1:0];
        n_b    = n_p[sca_pkg::BIT_W-1:0];
        widx_x = {1'b0, r_widx};
        for (int b = 0; b < sca_pkg::WORD_BITS; b++) begin
            elig[b] = !r_rd_data[b]
                   && ((widx_x != hint_w) || (sca_pkg::BIT_W'(b) >= hint_b))
                   && ((widx_x < n_w) || ((widx_x == n_w) && (sca_pkg::BIT_W'(b) < n_b)));
        end
        a_sel = '0;
        for (int b = sca_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (elig[b]) a_sel = sca_pkg::BIT_W'(b);
        end
        a_found = |elig;
        a_idx   = IW'((PW'(r_widx) << sca_pkg::BIT_W) | PW'(a_sel));
        a_more  = ((PW'(r_widx) + PW'(1)) << sca_pkg::BIT_W) < n_p;
    end

    assign diff      = {1'b0, r_addr} - {1'b0, r_slab_base};
    assign range_bad = diff[sca_pkg::ADDR_W]
                    || (diff[sca_pkg::ADDR_W-1:0] >= sca_pkg::ADDR_W'(r_slab_bytes));

    // restoring divider, one quotient bit per cycle
    assign div_t  = {r_rem, r_quo[sca_pkg::CHUNK_W-1]};
    assign div_ge = div_t >= {1'b0, eff_chunk};

    assign idx_bad  = 32'(r_quo) >= 32'(n_c);
    assign bit_used = r_rd_data[r_bsel];

    assign mem_we    = i_cmd.clr || (i_cmd.a_eval && a_found) || (i_cmd.f_eval && bit_used);
    assign mem_waddr = i_cmd.clr ? r_clr_idx : r_widx;
    always_comb begin
        if (i_cmd.clr) begin
            mem_wdata = '0;
        end else if (i_cmd.a_eval) begin
            mem_wdata = r_rd_data | (sca_pkg::WORD_BITS'(1) << a_sel);
        end else begin
            mem_wdata = r_rd_data & ~(sca_pkg::WORD_BITS'(1) << r_bsel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rd_data <= r_mem[r_widx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slab_base   <= sca_pkg::RST_SLAB_BASE;
            r_chunk_bytes <= sca_pkg::RST_CHUNK_BYTES;
            r_slab_bytes  <= sca_pkg::RST_SLAB_BYTES;
            r_chunk_count <= sca_pkg::RST_CHUNK_COUNT;
            r_used_count  <= '0;
            r_hint        <= '0;
            r_clr_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sca_pkg::CFG_SLAB_BASE:   r_slab_base   <= i_cfg_data;
                    sca_pkg::CFG_CHUNK_BYTES: r_chunk_bytes <= i_cfg_data[sca_pkg::CHUNK_W-1:0];
                    sca_pkg::CFG_SLAB_BYTES:  r_slab_bytes  <= i_cfg_data[sca_pkg::CHUNK_W-1:0];
                    sca_pkg::CFG_CHUNK_COUNT: r_chunk_count <= i_cfg_data[sca_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr) r_clr_idx <= r_clr_idx + WAW'(1);
            if (i_cmd.a_eval && a_found) begin
                r_used_count <= r_used_count + CW'(1);
                r_hint       <= a_idx;
            end
            if (i_cmd.f_eval && bit_used) begin
                r_used_count <= r_used_count - CW'(1);
                if (r_idx < r_hint) r_hint <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PRW'(r_idx) * PRW'(eff_chunk);
        if (i_cmd.accept) begin
            r_mode      <= i_in_data.mode;
            r_addr      <= i_in_data.free_address;
            r_status    <= sca_pkg::STS_OK;
            r_idx       <= '0;
            r_left_full <= 1'b0;
            r_now_empty <= 1'b0;
            r_widx      <= WAW'(hint_p >> sca_pkg::BIT_W);
        end
        if (i_cmd.a_eval) begin
            if (a_found) begin
                r_idx <= a_idx;
            end else if (a_more) begin
                r_widx <= r_widx + WAW'(1);
            end else begin
                r_status <= sca_pkg::STS_NO_FREE;
            end
        end
        if (i_cmd.f_range) begin
            if (range_bad) r_status <= sca_pkg::STS_OUTSIDE;
            r_quo     <= diff[sca_pkg::CHUNK_W-1:0];
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= div_ge ? sca_pkg::CHUNK_W'(div_t - {1'b0, eff_chunk})
                                : sca_pkg::CHUNK_W'(div_t);
            r_quo     <= {r_quo[sca_pkg::CHUNK_W-2:0], div_ge};
            r_div_cnt <= r_div_cnt + sca_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.f_idx) begin
            if (idx_bad) begin
                r_status <= sca_pkg::STS_OUTSIDE;
            end else begin
                r_idx  <= IW'(r_quo);
                r_widx <= WAW'(r_quo >> sca_pkg::BIT_W);
                r_bsel <= r_quo[sca_pkg::BIT_W-1:0];
            end
        end
        if (i_cmd.f_eval) begin
            if (bit_used) begin
                r_left_full <= (r_used_count == n_c);
                r_now_empty <= (r_used_count == CW'(1));
            end else begin
                r_status <= sca_pkg::STS_DOUBLE_FREE;
            end
        end
        if (i_cmd.finish) begin
            r_out.status        <= r_status;
            r_out.chunk_address <= ((r_status == sca_pkg::STS_OK) && (r_mode == sca_pkg::MODE_ALLOC))
                                   ? r_slab_base + sca_pkg::ADDR_W'(r_prod) : '0;
            r_out.chunk_index   <= sca_pkg::IDX_W'(r_idx);
            r_out.allocated_now <= sca_pkg::COUNT_W'(r_used_count);
            r_out.has_room      <= (r_used_count < n_c);
            r_out.left_full     <= r_left_full;
            r_out.now_empty     <= r_now_empty;
        end
    end

    assign o_sts.clr_last  = (r_clr_idx == WAW'(WORDS - 1));
    assign o_sts.a_found   = a_found;
    assign o_sts.a_more    = a_more;
    assign o_sts.range_bad = range_bad;
    assign o_sts.div_last  = (r_div_cnt == sca_pkg::DIV_CNT_W'(sca_pkg::DIV_STEPS - 1));
    assign o_sts.idx_bad   = idx_bad;

    assign o_out_data = r_out;

endmodule

### sv/slab_chunk_allocator_core.sv
// top level of the slab chunk allocator: controller plus datapath
//
// channel   direction  handshake               payload
// in        sink       i_in_valid / o_in_stall  i_in_data   (mode, free_address)
// out       source     o_out_valid / i_out_stall o_out_data (status .. now_empty)
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// allocate: ARD, AEVAL per 32-bit map word from the hint word, AMUL if one is free, FINISH
// free: FRANGE, 17-step restoring divider, FIDX, FRD, FEVAL, FINISH; outside goes to FINISH
// one word at a time; the next word is taken once the result is registered
// after reset a clearing pass zeroes the ceil(MAX_CHUNKS/32) map words (8 by default)
// with o_in_stall high; config writes are taken throughout
// a held output word delays only the final result load
module slab_chunk_allocator_core #(
    parameter int MAX_CHUNKS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sca_pkg::t_in_word             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sca_pkg::t_out_word            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sca_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sca_pkg::ADDR_W-1:0]    i_cfg_data
);

    sca_pkg::t_cmd cmd;
    sca_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    sca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_data.mode),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    sca_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data)
    );

endmodule

### sv/sca_checker.sv
// port-level checks of the slab chunk allocator and their bind
`include "slab_chunk_allocator_core_defines.svh"

module sca_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sca_pkg::t_out_word o_out_data
);

    `SCA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    `SCA_ASSERT_SAME(a_addr_zero_on_error, i_clk, i_rst_n, o_out_valid && (o_out_data.status != sca_pkg::STS_OK), o_out_data.chunk_address == '0)

    `SCA_ASSERT_SAME(a_no_index_on_miss, i_clk, i_rst_n, o_out_valid && ((o_out_data.status == sca_pkg::STS_NO_FREE) || (o_out_data.status == sca_pkg::STS_OUTSIDE)), (o_out_data.chunk_index == '0) && !o_out_data.left_full && !o_out_data.now_empty)

    `SCA_ASSERT_SAME(a_empty_means_zero, i_clk, i_rst_n, o_out_valid && o_out_data.now_empty, (o_out_data.allocated_now == '0) && (o_out_data.status == sca_pkg::STS_OK))

    `SCA_ASSERT_SAME(a_left_full_has_room, i_clk, i_rst_n, o_out_valid && o_out_data.left_full, o_out_data.has_room && (o_out_data.status == sca_pkg::STS_OK))

endmodule

bind slab_chunk_allocator_core sca_checker u_sca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
